// File: sv/tbs_pkg.sv
// Shared types, codes and widths of the triangular block solver.
`timescale 1ns / 1ps

package tbs_pkg;

  // Fixed field and datapath widths (Q8.24 values)
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 24;
  localparam int ACC_W     = 48;
  localparam int MUL_A_W   = 33;
  localparam int PROD_W    = MUL_A_W + VAL_W;
  localparam int LO_W      = 34;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Item kinds
  localparam logic [1:0] KIND_TRI   = 2'd0;
  localparam logic [1:0] KIND_RHS   = 2'd1;
  localparam logic [1:0] KIND_SOLVE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STRIDE = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [1:0]              row;
    logic [2:0]              col;
    logic signed [VAL_W-1:0] value;
  } tbs_item_t;

  typedef struct packed {
    logic [1:0]              res_row;
    logic [2:0]              res_col;
    logic [31:0]             out_offset;
    logic signed [VAL_W-1:0] solution;
    logic                    last;
  } tbs_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELEM,
    ST_TERM_RD,
    ST_TERM_MUL,
    ST_TERM_ACC,
    ST_DIAG_RD,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_EMIT
  } tbs_state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_TERM,
    MOP_ACC,
    MOP_DIFF,
    MOP_LO,
    MOP_HI
  } tbs_mop_t;

  typedef struct packed {
    logic     clear_acc;
    tbs_mop_t op;
  } tbs_mac_ctl_t;

endpackage

// File: sv/tbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tbs_mac.sv
// Shared multiplier with accumulator, difference and saturation for the solver.
`timescale 1ns / 1ps

module tbs_mac import tbs_pkg::*; (
  input  logic                    clk,
  input  tbs_mac_ctl_t            ctl,
  input  logic signed [VAL_W-1:0] tri_rdata,
  input  logic signed [VAL_W-1:0] rhs_rdata,
  output logic signed [VAL_W-1:0] x_sat
);

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [VAL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  sum;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   diff;
  logic signed [VAL_W-1:0]   areg;
  logic signed [LO_W-1:0]    lo_term;

  // Select multiplier operands: off-diagonal term, or low/high half of the difference
  always_comb begin
    mul_a = {{(MUL_A_W-VAL_W){rhs_rdata[VAL_W-1]}}, rhs_rdata};
    mul_b = tri_rdata;
    case (ctl.op)
      MOP_LO: begin
        mul_a = {{(MUL_A_W-FRAC_W){1'b0}}, diff[FRAC_W-1:0]};
        mul_b = areg;
      end
      MOP_HI: begin
        mul_a = {{(MUL_A_W-(ACC_W-FRAC_W)){diff[ACC_W-1]}}, diff[ACC_W-1:FRAC_W]};
        mul_b = areg;
      end
      default: begin
      end
    endcase
  end

  // Floor of the product by 2^24, widened to the accumulator
  assign term = {{(ACC_W-(PROD_W-FRAC_W)){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_W]};

  // Register the product, accumulate, form the difference
  always_ff @(posedge clk) begin
    if (ctl.clear_acc) begin
      acc <= '0;
    end
    case (ctl.op)
      MOP_TERM: prod <= mul_a * mul_b;
      MOP_ACC:  acc  <= acc + term;
      MOP_DIFF: begin
        diff <= {{(ACC_W-VAL_W){rhs_rdata[VAL_W-1]}}, rhs_rdata} - acc;
        areg <= tri_rdata;
      end
      MOP_LO:   prod <= mul_a * mul_b;
      MOP_HI: begin
        lo_term <= prod[FRAC_W+LO_W-1:FRAC_W];
        prod    <= mul_a * mul_b;
      end
      default: begin
      end
    endcase
  end

  // Join the high product with the floored low part and saturate
  assign sum = prod + {{(PROD_W-LO_W){lo_term[LO_W-1]}}, lo_term};

  always_comb begin
    if ((&sum[PROD_W-1:VAL_W-1]) || !(|sum[PROD_W-1:VAL_W-1])) begin
      x_sat = sum[VAL_W-1:0];
    end else if (sum[PROD_W-1]) begin
      x_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

// File: sv/tbs_ctrl.sv
// Sequencer of the solver: loads, element and term counters, store addressing, results.
`timescale 1ns / 1ps

module tbs_ctrl import tbs_pkg::*; #(
  parameter int BLOCK_ROWS = 4,
  parameter int BLOCK_COLS = 8,
  parameter int TRI_AW     = 4,
  parameter int RHS_AW     = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  tbs_item_t               item,
  input  logic                    upper_mode,
  input  logic [CFG_W-1:0]        row_stride,
  input  logic [CFG_W-1:0]        col_stride,
  output tbs_mac_ctl_t            mac_ctl,
  input  logic signed [VAL_W-1:0] x_sat,
  output logic                    tri_we,
  output logic [TRI_AW-1:0]       tri_waddr,
  output logic [TRI_AW-1:0]       tri_raddr,
  output logic                    rhs_we,
  output logic [RHS_AW-1:0]       rhs_waddr,
  output logic [VAL_W-1:0]        rhs_wdata,
  output logic [RHS_AW-1:0]       rhs_raddr,
  output logic                    res_strobe,
  output tbs_result_t             result
);

  localparam int ROW_IW = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
  localparam int COL_IW = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
  localparam int RCNT_W = $clog2(BLOCK_ROWS + 1);
  localparam int IDX_W  = (ROW_IW > COL_IW) ? ROW_IW : COL_IW;
  localparam int OFF_W  = CFG_W + IDX_W + 1;

  tbs_state_t        state, state_next;
  logic [ROW_IW-1:0] i, i_next;
  logic [COL_IW-1:0] j, j_next;
  logic [RCNT_W-1:0] l, l_next;
  logic [RCNT_W-1:0] lo_l, hi_l;
  logic [ROW_IW-1:0] rd_l;
  logic              last_row, last_col;
  logic              take, load_tri, load_rhs;

  // Term range of the current row and end of sweep
  assign lo_l     = upper_mode ? (RCNT_W'(i) + 1'b1) : '0;
  assign hi_l     = upper_mode ? RCNT_W'(BLOCK_ROWS) : RCNT_W'(i);
  assign last_row = upper_mode ? (i == '0) : (i == ROW_IW'(BLOCK_ROWS - 1));
  assign last_col = (j == COL_IW'(BLOCK_COLS - 1));

  // Accept loads while idle, drop out-of-range ones
  assign busy     = (state != ST_IDLE);
  assign take     = start && !busy;
  assign load_tri = take && (item.kind == KIND_TRI) &&
                    (int'(item.row) < BLOCK_ROWS) && (int'(item.col) < BLOCK_ROWS);
  assign load_rhs = take && (item.kind == KIND_RHS) &&
                    (int'(item.row) < BLOCK_ROWS) && (int'(item.col) < BLOCK_COLS);

  // Store addressing: loads and write-back, term or diagonal reads
  assign rd_l      = (state == ST_TERM_RD) ? l[ROW_IW-1:0] : i;
  assign tri_we    = load_tri;
  assign tri_waddr = TRI_AW'(int'(item.row) * BLOCK_ROWS + int'(item.col));
  assign tri_raddr = TRI_AW'(int'(i) * BLOCK_ROWS + int'(rd_l));
  assign rhs_raddr = RHS_AW'(int'(rd_l) * BLOCK_COLS + int'(j));
  assign rhs_we    = load_rhs || (state == ST_EMIT);
  assign rhs_waddr = (state == ST_EMIT) ? RHS_AW'(int'(i) * BLOCK_COLS + int'(j))
                                        : RHS_AW'(int'(item.row) * BLOCK_COLS + int'(item.col));
  assign rhs_wdata = (state == ST_EMIT) ? x_sat : item.value;

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      l     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      l     <= l_next;
    end
  end

  // Next state, counters and shared unit control
  always_comb begin
    state_next        = state;
    i_next            = i;
    j_next            = j;
    l_next            = l;
    mac_ctl.clear_acc = 1'b0;
    mac_ctl.op        = MOP_NONE;
    case (state)
      ST_IDLE: begin
        if (take && (item.kind == KIND_SOLVE)) begin
          state_next = ST_ELEM;
          i_next     = upper_mode ? ROW_IW'(BLOCK_ROWS - 1) : '0;
          j_next     = '0;
        end
      end
      ST_ELEM: begin
        mac_ctl.clear_acc = 1'b1;
        l_next            = lo_l;
        state_next        = (lo_l < hi_l) ? ST_TERM_RD : ST_DIAG_RD;
      end
      ST_TERM_RD: begin
        state_next = ST_TERM_MUL;
      end
      ST_TERM_MUL: begin
        mac_ctl.op = MOP_TERM;
        state_next = ST_TERM_ACC;
      end
      ST_TERM_ACC: begin
        mac_ctl.op = MOP_ACC;
        l_next     = l + 1'b1;
        state_next = ((l + 1'b1) == hi_l) ? ST_DIAG_RD : ST_TERM_RD;
      end
      ST_DIAG_RD: begin
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        mac_ctl.op = MOP_DIFF;
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mac_ctl.op = MOP_LO;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mac_ctl.op = MOP_HI;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = ST_ELEM;
        if (last_col) begin
          j_next = '0;
          if (last_row) begin
            state_next = ST_IDLE;
          end else begin
            i_next = upper_mode ? (i - 1'b1) : (i + 1'b1);
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= (state == ST_EMIT);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      result.res_row    <= 2'(i);
      result.res_col    <= 3'(j);
      result.out_offset <= 32'(OFF_W'(i) * OFF_W'(row_stride) + OFF_W'(j) * OFF_W'(col_stride));
      result.solution   <= x_sat;
      result.last       <= last_row && last_col;
    end
  end

endmodule

// File: sv/triangular_block_solve.sv
// Solve: each element steps through ELEM, then TERM_RD, TERM_MUL and TERM_ACC for each
// off-diagonal term in its row, then DIAG_RD, DIFF, MUL_LO, MUL_HI and EMIT; busy stays high
// for the whole solve. The one shared multiplier and one read port per store serialise this.
// Loads are accepted while idle and leave busy low. Each result strobes in the cycle after
// its element's EMIT state; the last comes as busy falls. Reset clears the sequencer and sets the
// configuration to lower mode, row stride 1, column stride 4; stores hold nothing defined until written.
`timescale 1ns / 1ps

module triangular_block_solve import tbs_pkg::*; #(
  parameter int BLOCK_ROWS = 4,
  parameter int BLOCK_COLS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tbs_item_t            item,
  output logic                 res_strobe,
  output tbs_result_t          result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int TRI_DEPTH = BLOCK_ROWS * BLOCK_ROWS;
  localparam int RHS_DEPTH = BLOCK_ROWS * BLOCK_COLS;
  localparam int TRI_AW    = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
  localparam int RHS_AW    = (RHS_DEPTH > 1) ? $clog2(RHS_DEPTH) : 1;

  logic                    upper_mode;
  logic [CFG_W-1:0]        out_row_stride;
  logic [CFG_W-1:0]        out_col_stride;
  tbs_mac_ctl_t            mac_ctl;
  logic signed [VAL_W-1:0] x_sat;
  logic                    tri_we, rhs_we;
  logic [TRI_AW-1:0]       tri_waddr, tri_raddr;
  logic [RHS_AW-1:0]       rhs_waddr, rhs_raddr;
  logic [VAL_W-1:0]        rhs_wdata;
  logic [VAL_W-1:0]        tri_rdata, rhs_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_mode     <= 1'b0;
      out_row_stride <= 16'd1;
      out_col_stride <= 16'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_MODE: upper_mode     <= cfg_data[0];
        CFG_ROW_STRIDE: out_row_stride <= cfg_data;
        CFG_COL_STRIDE: out_col_stride <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tbs_ctrl #(
    .BLOCK_ROWS (BLOCK_ROWS),
    .BLOCK_COLS (BLOCK_COLS),
    .TRI_AW     (TRI_AW),
    .RHS_AW     (RHS_AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .upper_mode (upper_mode),
    .row_stride (out_row_stride),
    .col_stride (out_col_stride),
    .mac_ctl    (mac_ctl),
    .x_sat      (x_sat),
    .tri_we     (tri_we),
    .tri_waddr  (tri_waddr),
    .tri_raddr  (tri_raddr),
    .rhs_we     (rhs_we),
    .rhs_waddr  (rhs_waddr),
    .rhs_wdata  (rhs_wdata),
    .rhs_raddr  (rhs_raddr),
    .res_strobe (res_strobe),
    .result     (result)
  );

  tbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TRI_DEPTH),
    .AW    (TRI_AW)
  ) u_tri_store (
    .clk   (clk),
    .we    (tri_we),
    .waddr (tri_waddr),
    .wdata (item.value),
    .raddr (tri_raddr),
    .rdata (tri_rdata)
  );

  tbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RHS_DEPTH),
    .AW    (RHS_AW)
  ) u_rhs_store (
    .clk   (clk),
    .we    (rhs_we),
    .waddr (rhs_waddr),
    .wdata (rhs_wdata),
    .raddr (rhs_raddr),
    .rdata (rhs_rdata)
  );

  tbs_mac u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .tri_rdata (tri_rdata),
    .rhs_rdata (rhs_rdata),
    .x_sat     (x_sat)
  );

  // A solve transaction taken while idle makes the block busy
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.kind == KIND_SOLVE)) |=> busy)
    else $error("solve accepted but block not busy");

  // A load transaction leaves the block free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.kind != KIND_SOLVE)) |=> !busy)
    else $error("load held the block busy");

  // Only the last result arrives once the block is free
  a_last_free: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> (busy == !result.last))
    else $error("last flag disagrees with busy");

  // Each element steps through ELEM to EMIT before the next, so strobes never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    res_strobe |=> !res_strobe)
    else $error("result strobes in consecutive cycles");

endmodule
